[design/see_pkg.sv]
// shared types and constants for the stack expression evaluator
package see_pkg;

  localparam int unsigned StackDepth = 256;
  localparam int unsigned VarCount   = 64;
  localparam int unsigned SpW        = $clog2(StackDepth);
  localparam int unsigned DepthW     = $clog2(StackDepth + 1);
  localparam int unsigned VarW       = $clog2(VarCount);
  localparam logic [31:0] QOne       = 32'h0001_0000;

  typedef enum logic [4:0] {
    KIND_PUSH  = 5'd0,
    KIND_LOAD  = 5'd1,
    KIND_STORE = 5'd2,
    KIND_ADD   = 5'd3,
    KIND_SUB   = 5'd4,
    KIND_MUL   = 5'd5,
    KIND_DIV   = 5'd6,
    KIND_NEG   = 5'd7,
    KIND_GT    = 5'd8,
    KIND_LT    = 5'd9,
    KIND_EQ    = 5'd10,
    KIND_GE    = 5'd11,
    KIND_LE    = 5'd12,
    KIND_NE    = 5'd13,
    KIND_AND   = 5'd14,
    KIND_OR    = 5'd15,
    KIND_NOT   = 5'd16,
    KIND_PRINT = 5'd17
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_DIVZERO  = 3'd3,
    ST_UNDEF    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_RD,
    FSM_EXEC,
    FSM_MUL,
    FSM_DIV,
    FSM_WB,
    FSM_TOP,
    FSM_OUT
  } fsm_e;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

endpackage

[design/see_div.sv]
// iterative signed q16.16 divider with saturation, one quotient bit per cycle
module see_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  see_pkg::div_req_t req_i,
  output see_pkg::div_rsp_t rsp_o
);
  import see_pkg::*;

  // dividend |a|<<16 is 48 bits; quotient up to 48 bits
  logic [47:0] rem_q, rem_d;
  logic [47:0] quo_q, quo_d;
  logic [47:0] dvd_q, dvd_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [48:0] trial;
  logic [47:0] shifted;
  logic [31:0] abs_a, abs_b;
  logic [48:0] sq;
  logic [31:0] res;

  assign abs_a = req_i.num[31] ? (~req_i.num + 32'd1) : req_i.num;
  assign abs_b = req_i.den[31] ? (~req_i.den + 32'd1) : req_i.den;
  assign shifted = {rem_q[46:0], dvd_q[47]};
  assign trial = {1'b0, shifted} - {17'd0, den_q};

  // one restoring step per cycle
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvd_d  = dvd_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = '0;
      dvd_d  = {abs_a, 16'd0};
      den_d  = abs_b;
      neg_d  = req_i.num[31] ^ req_i.den[31];
      cnt_d  = 6'd47;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[46:0], 1'b0};
      if (!trial[48]) begin
        rem_d = trial[47:0];
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[46:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  // sign and saturate
  always_comb begin
    sq = neg_q ? (49'd0 - {1'b0, quo_q}) : {1'b0, quo_q};
    if (!neg_q && quo_q > 48'h0000_7FFF_FFFF) res = 32'h7FFF_FFFF;
    else if (neg_q && quo_q > 48'h0000_8000_0000) res = 32'h8000_0000;
    else res = sq[31:0];
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvd_q <= dvd_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end
endmodule

[design/stack_expression_evaluator.sv]
// top level of the stack expression evaluator
// Takes one stack-machine operation per transaction and returns one result
// transaction with status, top of stack (or printed value) and a printed flag.
// The operand stack and the variable store live in synchronous memories with
// one write port and a registered read; an operation reads the top two stack
// entries and the variable slot, computes, writes back, then re-reads the new
// top. Multiply adds a state for the product, and divide waits in a state for
// the one-bit-per-cycle divider, which spends 48 steps and then registers its
// done flag together with the final quotient. Operations are handled one at a
// time and a new one is taken only in the cycle after the result transaction.
module stack_expression_evaluator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [4:0]   kind_i,
  input  logic signed [31:0] value_i,
  input  logic [5:0]   var_index_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [2:0]   status_o,
  output logic signed [31:0] top_value_o,
  output logic         printed_o
);
  import see_pkg::*;

  logic [31:0] stk_mem [StackDepth];
  logic [31:0] var_mem [VarCount];
  logic [VarCount-1:0] def_q;

  fsm_e state_q, state_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [4:0]  kind_q;
  logic [31:0] val_q;
  logic [VarW-1:0] idx_q;
  logic [31:0] b_q, vr_q;
  logic [31:0] res_q, res_d;
  logic [2:0]  st_q, st_d;
  logic        pr_q, pr_d;
  logic        ov_q;
  logic [31:0] stat_top_q;
  logic [63:0] prod_q;

  // memory control
  logic             sw_en;
  logic [SpW-1:0]   sw_addr, sr_addr1, sr_addr2;
  logic [31:0]      sw_data;
  logic             vw_en;
  logic [31:0]      rd1_q;
  logic             rd_sel_d;

  div_req_t dreq;
  div_rsp_t drsp;

  see_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // stack memory: one write port, reads from a single address each cycle
  always_ff @(posedge clk_i) begin
    if (sw_en) stk_mem[sw_addr] <= sw_data;
    rd1_q <= stk_mem[rd_sel_d ? sr_addr2 : sr_addr1];
  end

  // variable memory
  always_ff @(posedge clk_i) begin
    if (vw_en) var_mem[idx_q] <= b_q;
    vr_q <= var_mem[idx_q];
  end

  logic signed [32:0] sum_add, sum_sub;
  logic signed [63:0] prod_s;
  logic [63:0] mulsh;
  logic [31:0] mulres;
  logic signed [31:0] sa, sb;
  logic [31:0] negres;
  logic        in_fire, out_fire;
  logic        is_bin, has1, has2;
  logic [31:0] cmp_res;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign in_ready_o = (state_q == FSM_IDLE) && !out_valid_o;
  // left operand comes straight from the read register during exec
  assign sa = rd1_q;
  assign sb = b_q;
  assign sum_add = {sa[31], sa} + {sb[31], sb};
  assign sum_sub = {sa[31], sa} - {sb[31], sb};
  assign has1 = depth_q != '0;
  assign has2 = depth_q > DepthW'(1);
  assign is_bin = (kind_q >= KIND_ADD && kind_q <= KIND_DIV) ||
                  (kind_q >= KIND_GT && kind_q <= KIND_OR);
  assign negres = (b_q == 32'h8000_0000) ? 32'h7FFF_FFFF : (~b_q + 32'd1);
  assign prod_s = sa * sb;
  assign mulsh = {{16{prod_q[63]}}, prod_q[63:16]};
  always_comb begin
    if ($signed(mulsh) > 64'sh7FFF_FFFF) mulres = 32'h7FFF_FFFF;
    else if ($signed(mulsh) < -64'sh8000_0000) mulres = 32'h8000_0000;
    else mulres = mulsh[31:0];
  end

  always_comb begin
    case (kind_q)
      KIND_GT:  cmp_res = (sa > sb)  ? QOne : '0;
      KIND_LT:  cmp_res = (sa < sb)  ? QOne : '0;
      KIND_EQ:  cmp_res = (sa == sb) ? QOne : '0;
      KIND_GE:  cmp_res = (sa >= sb) ? QOne : '0;
      KIND_LE:  cmp_res = (sa <= sb) ? QOne : '0;
      KIND_NE:  cmp_res = (sa != sb) ? QOne : '0;
      KIND_AND: cmp_res = (sa != '0 && sb != '0) ? QOne : '0;
      KIND_OR:  cmp_res = (sa != '0 || sb != '0) ? QOne : '0;
      default:  cmp_res = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    depth_d  = depth_q;
    res_d    = res_q;
    st_d     = st_q;
    pr_d     = pr_q;
    sw_en    = 1'b0;
    sw_addr  = '0;
    sw_data  = res_q;
    vw_en    = 1'b0;
    sr_addr1 = SpW'(depth_q - DepthW'(1));
    sr_addr2 = SpW'(depth_q - DepthW'(2));
    rd_sel_d = 1'b0;
    dreq.start = 1'b0;
    dreq.num   = rd1_q;
    dreq.den   = b_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_fire) state_d = FSM_RD;
      end
      // first cycle: top read issued, now issue second
      FSM_RD: begin
        rd_sel_d = 1'b1;
        state_d  = FSM_EXEC;
      end
      FSM_EXEC: begin
        st_d = ST_OK;
        pr_d = 1'b0;
        state_d = FSM_WB;
        case (kind_q)
          KIND_PUSH: begin
            if (ov_q) st_d = ST_OVERFLOW;
            else res_d = val_q;
          end
          KIND_LOAD: begin
            if (!def_q[idx_q]) st_d = ST_UNDEF;
            else if (ov_q) st_d = ST_OVERFLOW;
            else res_d = vr_q;
          end
          KIND_STORE: begin
            if (!has1) st_d = ST_UNDERFLOW;
          end
          KIND_NEG: begin
            if (!has1) st_d = ST_UNDERFLOW;
            else res_d = negres;
          end
          KIND_NOT: begin
            if (!has1) st_d = ST_UNDERFLOW;
            else res_d = (b_q == '0) ? QOne : '0;
          end
          KIND_PRINT: begin
            if (!has1) st_d = ST_UNDERFLOW;
            else begin
              res_d = b_q;
              pr_d  = 1'b1;
            end
          end
          default: begin
            if (is_bin) begin
              if (!has1) st_d = ST_UNDERFLOW;
              else if (kind_q == KIND_DIV && b_q == '0) st_d = ST_DIVZERO;
              else if (!has2) st_d = ST_UNDERFLOW;
              else if (kind_q == KIND_MUL) state_d = FSM_MUL;
              else if (kind_q == KIND_DIV) begin
                dreq.start = 1'b1;
                state_d = FSM_DIV;
              end else if (kind_q == KIND_ADD) begin
                res_d = (sum_add[32] != sum_add[31]) ?
                        (sum_add[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_add[31:0];
              end else if (kind_q == KIND_SUB) begin
                res_d = (sum_sub[32] != sum_sub[31]) ?
                        (sum_sub[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_sub[31:0];
              end else res_d = cmp_res;
            end
          end
        endcase
      end
      FSM_MUL: begin
        res_d = mulres;
        state_d = FSM_WB;
      end
      FSM_DIV: begin
        if (drsp.done) begin
          res_d = drsp.quo;
          state_d = FSM_WB;
        end
      end
      // write back and update depth
      FSM_WB: begin
        state_d = FSM_TOP;
        if (st_q != ST_OK) depth_d = '0;
        else begin
          case (kind_q)
            KIND_PUSH, KIND_LOAD: begin
              sw_en = 1'b1;
              sw_addr = SpW'(depth_q);
              depth_d = depth_q + DepthW'(1);
            end
            KIND_STORE: vw_en = 1'b1;
            KIND_NEG, KIND_NOT: begin
              sw_en = 1'b1;
              sw_addr = SpW'(depth_q - DepthW'(1));
            end
            KIND_PRINT: depth_d = depth_q - DepthW'(1);
            default: begin
              if (is_bin) begin
                sw_en = 1'b1;
                sw_addr = SpW'(depth_q - DepthW'(2));
                depth_d = depth_q - DepthW'(1);
              end
            end
          endcase
        end
      end
      // read the new top after write back
      FSM_TOP: begin
        state_d = FSM_OUT;
      end
      FSM_OUT: begin
        state_d = FSM_IDLE;
        if (st_q != ST_OK) res_d = '0;
        else if (!pr_q) res_d = has1 ? rd1_q : '0;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // operand capture: b is the top
  always_ff @(posedge clk_i) begin
    if (state_q == FSM_RD) b_q <= rd1_q;
    if (state_q == FSM_EXEC) prod_q <= prod_s;
    else if (state_q == FSM_MUL) prod_q <= prod_q;
    res_q <= res_d;
    st_q  <= st_d;
    pr_q  <= pr_d;
    if (in_fire) begin
      kind_q <= kind_i;
      val_q  <= value_i;
      idx_q  <= VarW'(var_index_i);
      ov_q   <= depth_q >= DepthW'(StackDepth);
    end
    if (state_q == FSM_OUT) stat_top_q <= res_d;
  end

  // state, depth, defined flags and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      depth_q  <= '0;
      def_q    <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q  <= state_d;
      depth_q  <= depth_d;
      if (vw_en) def_q[idx_q] <= 1'b1;
      if (state_q == FSM_OUT) out_valid_o <= 1'b1;
      else if (out_fire) out_valid_o <= 1'b0;
    end
  end

  assign status_o    = st_q;
  assign top_value_o = stat_top_q;
  assign printed_o   = pr_q;
endmodule

[design/see_checker.sv]
// port-level checks for the stack expression evaluator
module see_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [31:0] top_value_o,
  input logic        printed_o
);
  import see_pkg::*;

  // an error result never carries a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> top_value_o == '0 && !printed_o)
    else $error("error result with data");

  // a result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(top_value_o))
    else $error("result dropped");

  // no new operation taken while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken with pending result");

  // a result follows an accepted transaction only after processing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result too early");
endmodule

bind stack_expression_evaluator see_checker u_see_checker (.*);
